@@ src/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ffha_pkg.sv @@
`timescale 1ns / 1ps
package ffha_pkg;
    localparam logic [31:0] MIN_HOLE_BYTES = 32'd16;
    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

    // register indexes on the configuration channel
    localparam logic [0:0] REG_BASE   = 1'b0;
    localparam logic [0:0] REG_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_NO_FIT   = 3'd1,
        ST_FREED    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ASCAN,
        S_FSCAN,
        S_FREAD_PREV,
        S_FREAD_NEXT,
        S_FDECIDE,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_WRITE,
        S_DONE
    } state_t;

    localparam logic MODE_ALLOC = 1'b0;
endpackage

@@ src/ffha_table.sv @@
`timescale 1ns / 1ps
// hole table memory: one write port, one registered read port
module ffha_table #(
    parameter int MAX_HOLES = 16,
    parameter int ADDR_BITS = 32,
    parameter int IDX_BITS  = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_BITS-1:0]  waddr,
    input  logic [ADDR_BITS-1:0] wstart,
    input  logic [31:0]          wlength,
    input  logic [IDX_BITS-1:0]  raddr,
    output logic [ADDR_BITS-1:0] rstart,
    output logic [31:0]          rlength
);
    logic [ADDR_BITS-1:0] start_mem [MAX_HOLES];
    logic [31:0]          length_mem [MAX_HOLES];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            start_mem[waddr]  <= wstart;
            length_mem[waddr] <= wlength;
        end
        rstart  <= start_mem[raddr];
        rlength <= length_mem[raddr];
    end
endmodule

@@ src/first_fit_hole_allocator.sv @@
`timescale 1ns / 1ps
// first-fit hole allocator
// input channel: in_valid/in_ready carries mode, request_bytes, alignment,
// release_address and release_bytes; one result item per input item leaves on
// out_valid/out_ready with grant_address, grant_bytes and status.
// configuration channel: cfg_valid/cfg_ready, cfg_index 0 region_base,
// 1 region_length; a write reloads the table with one hole over the region.
// the hole table is a memory with one write and one registered read port; a
// sequencer walks it one entry per cycle. an allocate scans until a hole fits
// and that hole is then shrunk or removed; a free scans for its place and then
// merges, inserts a hole or is refused (table full); a null free is answered
// without a scan. the next item is taken at the earliest in the cycle after
// the result is taken. one item is worked on at a time.
// after reset the table holds one hole at base 0 with length 0. the result
// waits in an output register; while out_ready is low the block stays busy
// and takes no new item and no configuration write.
module first_fit_hole_allocator #(
    parameter int MAX_HOLES = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [31:0]          request_bytes,
    input  logic [31:0]          alignment,
    input  logic [31:0]          release_address,
    input  logic [31:0]          release_bytes,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          grant_address,
    output logic [31:0]          grant_bytes,
    output logic [2:0]           status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import ffha_pkg::*;

    localparam int IDX_BITS = $clog2(MAX_HOLES);
    localparam int CNT_BITS = $clog2(MAX_HOLES + 1);
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_HOLES);
    localparam int WIDE = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;

    state_t state_reg, state_next;
    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [31:0] rlen_reg, rlen_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] pos_reg, pos_next;
    logic [CNT_BITS-1:0] sh_reg, sh_next;
    logic mode_reg, mode_next;
    logic [32:0] size_reg, size_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [31:0] len_reg, len_next;
    logic [ADDR_BITS-1:0] ps_reg, ps_next;
    logic [31:0] pl_reg, pl_next;
    logic mp_reg, mp_next;
    logic [31:0] ga_reg, ga_next;
    logic [31:0] gb_reg, gb_next;
    status_t st_reg, st_next;
    logic [ADDR_BITS-1:0] wr_s_reg, wr_s_next;
    logic [31:0] wr_l_reg, wr_l_next;
    logic rd_pend_reg, rd_pend_next;
    logic ov_reg, ov_next;

    logic we;
    logic [IDX_BITS-1:0] waddr, raddr;
    logic [ADDR_BITS-1:0] wstart, rstart;
    logic [31:0] wlength, rlength;

    ffha_table #(.MAX_HOLES(MAX_HOLES), .ADDR_BITS(ADDR_BITS), .IDX_BITS(IDX_BITS)) u_tab (
        .clk(clk), .we(we), .waddr(waddr), .wstart(wstart), .wlength(wlength),
        .raddr(raddr), .rstart(rstart), .rlength(rlength)
    );

    // merge test: (s,l) followed by ns within the minimum gap
    function automatic logic close_gap(input logic [ADDR_BITS-1:0] s,
                                       input logic [31:0] l,
                                       input logic [ADDR_BITS-1:0] ns);
        logic [WIDE-1:0] d;
        logic [WIDE-1:0] dl;
        begin
            d  = WIDE'(ns) - WIDE'(s);
            dl = d - WIDE'(l);
            close_gap = (ns >= s) && (d >= WIDE'(l))
                && (dl < WIDE'(MIN_HOLE_BYTES));
        end
    endfunction

    // saturated length from s to the end of (ns, nl)
    function automatic logic [31:0] span(input logic [ADDR_BITS-1:0] s,
                                         input logic [ADDR_BITS-1:0] ns,
                                         input logic [31:0] nl);
        logic [WIDE-1:0] d;
        logic [WIDE-1:0] t;
        begin
            d = WIDE'(ns) - WIDE'(s);
            t = d + WIDE'(nl);
            if (d >= WIDE'(LEN_MAX) || t > WIDE'(LEN_MAX))
                span = LEN_MAX;
            else
                span = t[31:0];
        end
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign out_valid = ov_reg;
    assign grant_address = ga_reg;
    assign grant_bytes   = gb_reg;
    assign status        = st_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            base_reg    <= '0;
            rlen_reg    <= '0;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            rlen_reg    <= rlen_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            ov_reg      <= ov_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        sh_reg   <= sh_next;
        mode_reg <= mode_next;
        size_reg <= size_next;
        addr_reg <= addr_next;
        len_reg  <= len_next;
        ps_reg   <= ps_next;
        pl_reg   <= pl_next;
        mp_reg   <= mp_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        st_reg   <= st_next;
        wr_s_reg <= wr_s_next;
        wr_l_reg <= wr_l_next;
    end

    // sequencer
    always_comb
    begin
        logic [32:0] rnd;
        logic [31:0] am;
        logic        mn;
        logic [ADDR_BITS-1:0] cs;
        logic [31:0] cl;
        state_next = state_reg;
        base_next = base_reg; rlen_next = rlen_reg; count_next = count_reg;
        pos_next = pos_reg; sh_next = sh_reg; mode_next = mode_reg;
        size_next = size_reg; addr_next = addr_reg; len_next = len_reg;
        ps_next = ps_reg; pl_next = pl_reg; mp_next = mp_reg;
        ga_next = ga_reg; gb_next = gb_reg; st_next = st_reg;
        wr_s_next = wr_s_reg; wr_l_next = wr_l_reg;
        rd_pend_next = 1'b0; ov_next = ov_reg;
        we = 1'b0; waddr = '0; wstart = '0; wlength = '0;
        raddr = pos_reg[IDX_BITS-1:0];
        am = alignment - 32'd1;
        rnd = {1'b0, request_bytes} + {1'b0, am};
        mn = 1'b0; cs = '0; cl = '0;
        case (state_reg)
            S_INIT:
            begin
                we = 1'b1; waddr = '0; wstart = base_reg; wlength = rlen_reg;
                count_next = CNT_BITS'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    if (cfg_index == REG_BASE)
                        base_next = ADDR_BITS'(cfg_data);
                    else
                        rlen_next = cfg_data;
                    state_next = S_INIT;
                end
                else if (in_valid)
                begin
                    mode_next = mode;
                    ga_next = '0; gb_next = '0;
                    addr_next = ADDR_BITS'(release_address);
                    len_next = release_bytes;
                    pos_next = '0; raddr = '0; rd_pend_next = 1'b1;
                    mp_next = 1'b0;
                    if (alignment == 32'd0)
                        size_next = {1'b0, request_bytes};
                    else
                        size_next = rnd & {1'b1, ~am};
                    if (mode == MODE_ALLOC)
                    begin
                        st_next = ST_NO_FIT;
                        state_next = S_ASCAN;
                    end
                    else if (ADDR_BITS'(release_address) == '0)
                    begin
                        st_next = ST_NULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        st_next = ST_FREED;
                        state_next = S_FSCAN;
                    end
                end
            end
            S_ASCAN:
            begin
                // read data for pos_reg valid when rd_pend_reg
                if (size_reg[32] || pos_reg >= count_reg)
                    state_next = S_DONE;
                else if (rd_pend_reg)
                begin
                    if ({1'b0, rlength} >= size_reg)
                    begin
                        ga_next = 32'(rstart);
                        st_next = ST_GRANTED;
                        if (rlength - size_reg[31:0] < MIN_HOLE_BYTES)
                        begin
                            gb_next = rlength;
                            sh_next = pos_reg;
                            raddr = IDX_BITS'(pos_reg + 1'b1);
                            state_next = S_SHIFT_DN;
                            rd_pend_next = 1'b1;
                        end
                        else
                        begin
                            gb_next = size_reg[31:0];
                            we = 1'b1; waddr = pos_reg[IDX_BITS-1:0];
                            wstart = rstart + ADDR_BITS'(size_reg[31:0]);
                            wlength = rlength - size_reg[31:0];
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                        raddr = IDX_BITS'(pos_reg + 1'b1);
                        rd_pend_next = 1'b1;
                    end
                end
                else
                    rd_pend_next = 1'b1;
            end
            S_SHIFT_DN:
            begin
                // entry sh+1 read out, write into sh
                if (sh_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else if (rd_pend_reg)
                begin
                    we = 1'b1; waddr = sh_reg[IDX_BITS-1:0];
                    wstart = rstart; wlength = rlength;
                    sh_next = sh_reg + 1'b1;
                    raddr = IDX_BITS'(sh_reg + 2'd2);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    raddr = IDX_BITS'(sh_reg + 1'b1);
                    rd_pend_next = 1'b1;
                end
            end
            S_FSCAN:
            begin
                // find first hole with start > addr, remembering predecessor
                if (pos_reg >= count_reg)
                    state_next = S_FDECIDE;
                else if (rd_pend_reg)
                begin
                    if (rstart <= addr_reg)
                    begin
                        ps_next = rstart; pl_next = rlength; mp_next = 1'b1;
                        pos_next = pos_reg + 1'b1;
                        raddr = IDX_BITS'(pos_reg + 1'b1);
                        rd_pend_next = 1'b1;
                    end
                    else
                    begin
                        wr_s_next = rstart; wr_l_next = rlength;
                        state_next = S_FDECIDE;
                    end
                end
                else
                    rd_pend_next = 1'b1;
            end
            S_FDECIDE:
            begin
                // ps/pl = predecessor (if mp), wr_s/wr_l = successor (if pos<count)
                if (mp_reg && close_gap(ps_reg, pl_reg, addr_reg))
                begin
                    cs = ps_reg; cl = span(ps_reg, addr_reg, len_reg);
                end
                else
                begin
                    cs = addr_reg; cl = len_reg;
                end
                mn = (pos_reg < count_reg) && close_gap(cs, cl, wr_s_reg);
                if (mp_reg && close_gap(ps_reg, pl_reg, addr_reg))
                begin
                    we = 1'b1;
                    waddr = IDX_BITS'(pos_reg - 1'b1);
                    wstart = cs;
                    wlength = mn ? span(cs, wr_s_reg, wr_l_reg) : cl;
                    if (mn)
                    begin
                        sh_next = pos_reg;
                        raddr = IDX_BITS'(pos_reg + 1'b1);
                        rd_pend_next = 1'b1;
                        state_next = S_SHIFT_DN;
                    end
                    else
                        state_next = S_DONE;
                end
                else if (mn)
                begin
                    we = 1'b1; waddr = pos_reg[IDX_BITS-1:0];
                    wstart = addr_reg;
                    wlength = span(addr_reg, wr_s_reg, wr_l_reg);
                    state_next = S_DONE;
                end
                else if (count_reg >= CNT_MAX)
                begin
                    st_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    sh_next = count_reg;
                    state_next = S_SHIFT_UP;
                    if (count_reg != '0)
                        raddr = IDX_BITS'(count_reg - 1'b1);
                    rd_pend_next = 1'b1;
                end
            end
            S_SHIFT_UP:
            begin
                // move entry sh-1 to sh while sh > pos, then write new hole
                if (sh_reg <= pos_reg)
                begin
                    we = 1'b1; waddr = pos_reg[IDX_BITS-1:0];
                    wstart = addr_reg; wlength = len_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
                else if (rd_pend_reg)
                begin
                    we = 1'b1; waddr = sh_reg[IDX_BITS-1:0];
                    wstart = rstart; wlength = rlength;
                    sh_next = sh_reg - 1'b1;
                    raddr = IDX_BITS'(sh_reg - 2'd2);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    raddr = IDX_BITS'(sh_reg - 1'b1);
                    rd_pend_next = 1'b1;
                end
            end
            S_DONE:
            begin
                ov_next = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // hold result until taken
                if (out_ready)
                begin
                    ov_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

@@ src/ffha_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// port-level checks for the allocator
module ffha_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] grant_address,
    input logic [31:0] grant_bytes,
    input logic [2:0]  status
);
    import ffha_pkg::*;

    // no new item while a result is pending
    `CHK_IMPL(a_busy_out, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
    // an accepted item blocks input next cycle
    `CHK_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "second item accepted")
    // failures and frees carry zero grant
    `CHK_IMPL(a_zero_grant, clk, rst_n, out_valid && (status != ST_GRANTED),
        grant_address == 32'd0 && grant_bytes == 32'd0, "nonzero grant without grant")
    // status codes stay in range
    `CHK_IMPL(a_status, clk, rst_n, out_valid, status <= ST_NULL, "bad status")
    // stalled result holds
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status),
        "result dropped")
endmodule

bind first_fit_hole_allocator ffha_port_checks u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .grant_address(grant_address), .grant_bytes(grant_bytes), .status(status)
);
